@@ rtl/lobm_pkg.sv @@
package lobm_pkg;

  localparam int MaxOrders = 64;
  localparam int IdxW      = $clog2(MaxOrders);
  localparam int CntW      = $clog2(MaxOrders + 1);
  localparam int QDepth    = 2;
  localparam int QPtrW     = $clog2(QDepth);
  localparam int QCntW     = $clog2(QDepth + 1);

  typedef enum logic [2:0] {
    STATUS_OK      = 3'd0,
    STATUS_UNKNOWN = 3'd1,
    STATUS_FULL    = 3'd2,
    STATUS_DUP     = 3'd3,
    STATUS_ZERO    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_FILL_B,
    S_FILL_A
  } state_e;

  typedef struct packed {
    logic        action;
    logic [31:0] order_id;
    logic        side;
    logic [31:0] price;
    logic [7:0]  quantity;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] best_bid;
    logic        bid_valid;
    logic [31:0] best_ask;
    logic        ask_valid;
    logic [6:0]  trade_count;
    logic [7:0]  filled_quantity;
  } rsp_t;

  typedef struct packed {
    req_t req;
    logic is_cancel;
    logic zero_qty;
  } cmd_t;

endpackage

@@ rtl/lobm_front.sv @@
module lobm_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  lobm_pkg::req_t req_i,
  output logic          busy,
  output logic          cmd_valid_o,
  output lobm_pkg::cmd_t cmd_o,
  input  logic          cmd_pop_i
);

  lobm_pkg::cmd_t                  fifo_q [lobm_pkg::QDepth];
  logic [lobm_pkg::QPtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [lobm_pkg::QCntW-1:0]      cnt_q;
  logic                            push, pop;
  lobm_pkg::cmd_t                  cmd_in;

  assign busy        = (cnt_q == lobm_pkg::QCntW'(lobm_pkg::QDepth));
  assign push        = start && !busy;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_comb begin
    cmd_in.req       = req_i;
    cmd_in.is_cancel = req_i.action;
    cmd_in.zero_qty  = (req_i.quantity == 8'd0);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ rtl/lobm_back.sv @@
module lobm_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  lobm_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           done_o,
  output lobm_pkg::rsp_t rsp_o
);

  localparam int IW = lobm_pkg::IdxW;
  localparam int CW = lobm_pkg::CntW;

  logic [31:0] id_mem    [lobm_pkg::MaxOrders];
  logic        side_mem  [lobm_pkg::MaxOrders];
  logic [31:0] price_mem [lobm_pkg::MaxOrders];
  logic [7:0]  rem_mem   [lobm_pkg::MaxOrders];
  logic [31:0] arr_mem   [lobm_pkg::MaxOrders];

  lobm_pkg::state_e state_q, state_d;
  lobm_pkg::cmd_t   cmd_q;

  logic [lobm_pkg::MaxOrders-1:0] valid_q;
  logic [31:0] arrival_q;
  logic        looked_q, matching_q;
  logic [CW-1:0] guard_q;
  logic [IW-1:0] addr_q, rd_idx_q, new_idx_q;
  logic        issue_q, rd_v_q;

  logic [31:0] rd_id_q, rd_price_q, rd_arr_q;
  logic        rd_side_q;
  logic [7:0]  rd_rem_q;

  logic          found_v_q, free_v_q, bid_v_q, ask_v_q;
  logic [IW-1:0] found_idx_q, free_idx_q, bid_idx_q, ask_idx_q;
  logic [31:0]   bid_price_q, ask_price_q, bid_age_q, ask_age_q;
  logic [7:0]    bid_rem_q, ask_rem_q;

  lobm_pkg::status_e status_q;
  logic [6:0]  trades_q;
  logic [7:0]  filled_q;
  logic        done_q;
  lobm_pkg::rsp_t rsp_q;

  logic        scan_last, scan_start, do_fill, place_ok, cancel_hit, emit;
  logic        we_full, we_rem;
  logic [IW-1:0] wa;
  logic [7:0]  w_rem, fill;
  logic        e_valid, bid_better, ask_better, id_hit;
  logic [31:0] e_age;
  logic [8:0]  filled_sum;

  assign scan_last = rd_v_q && (rd_idx_q == IW'(lobm_pkg::MaxOrders - 1));
  assign do_fill   = matching_q && (guard_q < CW'(lobm_pkg::MaxOrders)) && bid_v_q &&
                     ask_v_q && (bid_price_q >= ask_price_q);
  assign fill      = (bid_rem_q < ask_rem_q) ? bid_rem_q : ask_rem_q;
  assign filled_sum = {1'b0, filled_q} + {1'b0, fill};

  assign e_valid    = valid_q[rd_idx_q];
  assign e_age      = arrival_q - rd_arr_q;
  assign id_hit     = e_valid && (rd_id_q == cmd_q.req.order_id);
  assign bid_better = e_valid && !rd_side_q &&
                      (!bid_v_q || (rd_price_q > bid_price_q) ||
                       ((rd_price_q == bid_price_q) && (e_age > bid_age_q)));
  assign ask_better = e_valid && rd_side_q &&
                      (!ask_v_q || (rd_price_q < ask_price_q) ||
                       ((rd_price_q == ask_price_q) && (e_age > ask_age_q)));

  always_comb begin
    state_d = state_q;
    case (state_q)
      lobm_pkg::S_IDLE:   if (cmd_valid_i) state_d = lobm_pkg::S_SCAN;
      lobm_pkg::S_SCAN:   if (scan_last) state_d = lobm_pkg::S_DECIDE;
      lobm_pkg::S_DECIDE: begin
        if (!looked_q) state_d = lobm_pkg::S_SCAN;
        else if (do_fill) state_d = lobm_pkg::S_FILL_B;
        else state_d = lobm_pkg::S_IDLE;
      end
      lobm_pkg::S_FILL_B: state_d = lobm_pkg::S_FILL_A;
      lobm_pkg::S_FILL_A: state_d = lobm_pkg::S_SCAN;
      default:            state_d = lobm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop_o  = (state_q == lobm_pkg::S_IDLE) && cmd_valid_i;
    scan_start = (state_d == lobm_pkg::S_SCAN) && (state_q != lobm_pkg::S_SCAN);
    place_ok   = (state_q == lobm_pkg::S_DECIDE) && !looked_q && !cmd_q.is_cancel &&
                 !cmd_q.zero_qty && !found_v_q && free_v_q;
    cancel_hit = (state_q == lobm_pkg::S_DECIDE) && !looked_q && cmd_q.is_cancel &&
                 found_v_q;
    emit       = (state_q == lobm_pkg::S_DECIDE) && looked_q && !do_fill;
    we_full    = place_ok;
    we_rem     = (state_q == lobm_pkg::S_FILL_B) || (state_q == lobm_pkg::S_FILL_A);
    wa         = free_idx_q;
    w_rem      = cmd_q.req.quantity;
    if (state_q == lobm_pkg::S_FILL_B) begin
      wa    = bid_idx_q;
      w_rem = bid_rem_q - fill;
    end else if (state_q == lobm_pkg::S_FILL_A) begin
      wa    = ask_idx_q;
      w_rem = ask_rem_q - fill;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_full) begin
      id_mem[wa]    <= cmd_q.req.order_id;
      side_mem[wa]  <= cmd_q.req.side;
      price_mem[wa] <= cmd_q.req.price;
      arr_mem[wa]   <= arrival_q;
    end
    if (we_full || we_rem) begin
      rem_mem[wa] <= w_rem;
    end
    rd_id_q    <= id_mem[addr_q];
    rd_side_q  <= side_mem[addr_q];
    rd_price_q <= price_mem[addr_q];
    rd_rem_q   <= rem_mem[addr_q];
    rd_arr_q   <= arr_mem[addr_q];
    if (cmd_pop_o) cmd_q <= cmd_i;
    if (emit) begin
      rsp_q.status          <= status_q;
      rsp_q.best_bid        <= bid_v_q ? bid_price_q : 32'd0;
      rsp_q.bid_valid       <= bid_v_q;
      rsp_q.best_ask        <= ask_v_q ? ask_price_q : 32'd0;
      rsp_q.ask_valid       <= ask_v_q;
      rsp_q.trade_count     <= trades_q;
      rsp_q.filled_quantity <= filled_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lobm_pkg::S_IDLE;
      valid_q     <= '0;
      arrival_q   <= '0;
      looked_q    <= 1'b0;
      matching_q  <= 1'b0;
      guard_q     <= '0;
      addr_q      <= '0;
      rd_idx_q    <= '0;
      new_idx_q   <= '0;
      issue_q     <= 1'b0;
      rd_v_q      <= 1'b0;
      found_v_q   <= 1'b0;
      free_v_q    <= 1'b0;
      bid_v_q     <= 1'b0;
      ask_v_q     <= 1'b0;
      found_idx_q <= '0;
      free_idx_q  <= '0;
      bid_idx_q   <= '0;
      ask_idx_q   <= '0;
      bid_price_q <= '0;
      ask_price_q <= '0;
      bid_age_q   <= '0;
      ask_age_q   <= '0;
      bid_rem_q   <= '0;
      ask_rem_q   <= '0;
      status_q    <= lobm_pkg::STATUS_OK;
      trades_q    <= '0;
      filled_q    <= '0;
      done_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= emit;

      if (cmd_pop_o) begin
        looked_q   <= 1'b0;
        matching_q <= 1'b0;
        guard_q    <= '0;
        status_q   <= lobm_pkg::STATUS_OK;
        trades_q   <= '0;
        filled_q   <= '0;
      end

      // read pipeline: address issued in the cycle before its data is used
      rd_v_q   <= issue_q;
      rd_idx_q <= addr_q;
      if (scan_start) begin
        addr_q    <= '0;
        issue_q   <= 1'b1;
        found_v_q <= 1'b0;
        free_v_q  <= 1'b0;
        bid_v_q   <= 1'b0;
        ask_v_q   <= 1'b0;
      end else if (issue_q) begin
        if (addr_q == IW'(lobm_pkg::MaxOrders - 1)) issue_q <= 1'b0;
        else addr_q <= addr_q + 1'b1;
      end

      if (rd_v_q) begin
        if (id_hit && !found_v_q) begin
          found_v_q   <= 1'b1;
          found_idx_q <= rd_idx_q;
        end
        if (!e_valid && !free_v_q) begin
          free_v_q   <= 1'b1;
          free_idx_q <= rd_idx_q;
        end
        if (bid_better) begin
          bid_v_q     <= 1'b1;
          bid_idx_q   <= rd_idx_q;
          bid_price_q <= rd_price_q;
          bid_age_q   <= e_age;
          bid_rem_q   <= rd_rem_q;
        end
        if (ask_better) begin
          ask_v_q     <= 1'b1;
          ask_idx_q   <= rd_idx_q;
          ask_price_q <= rd_price_q;
          ask_age_q   <= e_age;
          ask_rem_q   <= rd_rem_q;
        end
      end

      if ((state_q == lobm_pkg::S_DECIDE) && !looked_q) begin
        looked_q <= 1'b1;
        if (cmd_q.is_cancel) begin
          if (!found_v_q) status_q <= lobm_pkg::STATUS_UNKNOWN;
        end else if (cmd_q.zero_qty) begin
          status_q <= lobm_pkg::STATUS_ZERO;
        end else if (found_v_q) begin
          status_q <= lobm_pkg::STATUS_DUP;
        end else if (!free_v_q) begin
          status_q <= lobm_pkg::STATUS_FULL;
        end
      end
      if (cancel_hit) valid_q[found_idx_q] <= 1'b0;
      if (place_ok) begin
        valid_q[free_idx_q] <= 1'b1;
        arrival_q           <= arrival_q + 32'd1;
        new_idx_q           <= free_idx_q;
        matching_q          <= 1'b1;
      end

      if (state_q == lobm_pkg::S_FILL_B) begin
        if (bid_rem_q == fill) valid_q[bid_idx_q] <= 1'b0;
      end
      if (state_q == lobm_pkg::S_FILL_A) begin
        if (ask_rem_q == fill) valid_q[ask_idx_q] <= 1'b0;
        if (trades_q != 7'd127) trades_q <= trades_q + 7'd1;
        guard_q <= guard_q + 1'b1;
        if ((bid_idx_q == new_idx_q) || (ask_idx_q == new_idx_q)) begin
          filled_q <= filled_sum[8] ? 8'd255 : filled_sum[7:0];
        end
      end
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

@@ rtl/limit_order_book_matcher_core.sv @@
// channel   | ports                    | handshake
// request   | start, req_i, busy       | taken when start && !busy
// result    | done_o, rsp_o            | one-cycle strobe, no back-pressure
// Front queue holds two requests; busy rises only when it is full.
// Per request the engine makes one lookup scan over all MaxOrders entries, then
// one book scan, plus per fill the write states FILL_B and FILL_A and another
// book scan; each scan reads the table entry by entry through its single
// read port.
// Reset clears valid bits, arrival counter and queue; table data is not cleared.
module limit_order_book_matcher_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  lobm_pkg::req_t req_i,
  output logic           busy,
  output logic           done_o,
  output lobm_pkg::rsp_t rsp_o
);

  logic           cmd_valid, cmd_pop;
  lobm_pkg::cmd_t cmd;

  lobm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .req_i       (req_i),
    .busy        (busy),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  lobm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .done_o      (done_o),
    .rsp_o       (rsp_o)
  );

endmodule
